@@ hdl/lkt_pkg.sv @@
// Shared constants and codes for the linear key table.
package lkt_pkg;

  localparam int SLOTS = 64;

  localparam int OpW   = 3;
  localparam int KeyW  = 32;
  localparam int WgtW  = 32;
  localparam int StW   = 2;
  localparam int SlotW = 6;
  localparam int FillW = 7;
  localparam int SumW  = 38;

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntW = $clog2(SLOTS + 1);
  localparam int AccW = (WgtW + 1 + IdxW > SumW) ? (WgtW + 1 + IdxW) : SumW;

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 3'd0,
    OP_FIND   = 3'd1,
    OP_REMOVE = 3'd2,
    OP_TOTAL  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

endpackage

@@ hdl/lkt_if.sv @@
// Request and response channel interfaces of the linear key table.
interface lkt_req_if;
  logic                              valid;
  logic                              ready;
  logic        [lkt_pkg::OpW-1:0]    op;
  logic signed [lkt_pkg::KeyW-1:0]   key;
  logic signed [lkt_pkg::WgtW-1:0]   weight;

  modport source (output valid, output op, output key, output weight, input ready);
  modport sink   (input valid, input op, input key, input weight, output ready);
endinterface

interface lkt_rsp_if;
  logic                              valid;
  logic                              ready;
  logic        [lkt_pkg::StW-1:0]    status;
  logic        [lkt_pkg::SlotW-1:0]  slot_index;
  logic signed [lkt_pkg::WgtW-1:0]   found_weight;
  logic signed [lkt_pkg::SumW-1:0]   weight_sum;
  logic        [lkt_pkg::FillW-1:0]  fill_count;

  modport source (output valid, output status, output slot_index, output found_weight,
                  output weight_sum, output fill_count, input ready);
  modport sink   (input valid, input status, input slot_index, input found_weight,
                  input weight_sum, input fill_count, output ready);
endinterface

@@ hdl/linear_key_table.sv @@
// Linear key table: add, find, remove, total and clear over a dense entry memory.
// Add, clear and unknown operations go straight to the response state once accepted.
// Find, remove and total scan one entry per cycle, find and remove stopping at a hit;
// an empty table skips the scan, and a remove hit moves the last entry into its slot.
// One request is worked at a time; a new request is taken once the result is registered.
// Reset empties the table at once; the entry memory itself is not cleared.
module linear_key_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  lkt_req_if.sink     req_i,
  lkt_rsp_if.source   rsp_o
);
  import lkt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_RESP
  } state_e;

  localparam logic signed [AccW-1:0] SumHi = {{(AccW-SumW+1){1'b0}}, {(SumW-1){1'b1}}};
  localparam logic signed [AccW-1:0] SumLo = {{(AccW-SumW+1){1'b1}}, {(SumW-1){1'b0}}};

  logic        [KeyW-1:0] key_mem [SLOTS];
  logic signed [WgtW-1:0] wgt_mem [SLOTS];

  state_e                 state_q;
  logic        [CntW-1:0] count_q;
  logic        [CntW-1:0] ra_q;
  logic                   pend_q;
  logic        [IdxW-1:0] cmp_idx_q;
  logic        [OpW-1:0]  op_q;
  logic        [KeyW-1:0] key_q;
  logic signed [AccW-1:0] acc_q;
  logic        [StW-1:0]  res_st_q;
  logic        [IdxW-1:0] res_idx_q;
  logic signed [WgtW-1:0] res_fw_q;
  logic        [KeyW-1:0] rd_key_q;
  logic signed [WgtW-1:0] rd_wgt_q;

  logic                   rsp_valid_q;
  logic        [StW-1:0]  rsp_st_q;
  logic        [SlotW-1:0] rsp_idx_q;
  logic signed [WgtW-1:0] rsp_fw_q;
  logic signed [SumW-1:0] rsp_sum_q;
  logic        [FillW-1:0] rsp_fill_q;

  logic                   mem_we;
  logic        [IdxW-1:0] mem_wa;
  logic        [KeyW-1:0] mem_wkey;
  logic signed [WgtW-1:0] mem_wwgt;
  logic        [IdxW-1:0] mem_ra;
  logic        [CntW-1:0] last_c;
  logic                   accept;
  logic signed [SumW-1:0] sum_sat;

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign last_c      = count_q - CntW'(1);

  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = count_q[IdxW-1:0];
    mem_wkey = req_i.key;
    mem_wwgt = req_i.weight;
    if (accept && (req_i.op == OP_ADD) && (count_q != CntW'(SLOTS))) begin
      mem_we = 1'b1;
    end else if (state_q == S_MOVE_WR) begin
      mem_we   = 1'b1;
      mem_wa   = res_idx_q;
      mem_wkey = rd_key_q;
      mem_wwgt = rd_wgt_q;
    end
    mem_ra = (state_q == S_SCAN) ? ra_q[IdxW-1:0] : last_c[IdxW-1:0];
  end

  always_comb begin
    if (acc_q > SumHi) begin
      sum_sat = SumHi[SumW-1:0];
    end else if (acc_q < SumLo) begin
      sum_sat = SumLo[SumW-1:0];
    end else begin
      sum_sat = acc_q[SumW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[mem_wa] <= mem_wkey;
      wgt_mem[mem_wa] <= mem_wwgt;
    end
    rd_key_q <= key_mem[mem_ra];
    rd_wgt_q <= wgt_mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (rsp_o.ready && (state_q != S_RESP)) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            op_q     <= req_i.op;
            key_q    <= req_i.key;
            acc_q    <= '0;
            res_fw_q <= '0;
            ra_q     <= '0;
            pend_q   <= 1'b0;
            case (req_i.op) inside
              OP_ADD: begin
                state_q <= S_RESP;
                if (count_q == CntW'(SLOTS)) begin
                  res_st_q  <= ST_FULL;
                  res_idx_q <= '0;
                end else begin
                  res_st_q  <= ST_OK;
                  res_idx_q <= count_q[IdxW-1:0];
                  count_q   <= count_q + CntW'(1);
                end
              end
              OP_FIND, OP_REMOVE, OP_TOTAL: begin
                res_idx_q <= '0;
                if (count_q == '0) begin
                  state_q  <= S_RESP;
                  res_st_q <= (req_i.op == OP_TOTAL) ? ST_OK : ST_MISSING;
                end else begin
                  state_q  <= S_SCAN;
                  res_st_q <= ST_OK;
                end
              end
              OP_CLEAR: begin
                state_q   <= S_RESP;
                res_st_q  <= ST_OK;
                res_idx_q <= '0;
                count_q   <= '0;
              end
              default: begin
                state_q   <= S_RESP;
                res_st_q  <= ST_OK;
                res_idx_q <= '0;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (ra_q < count_q) begin
            ra_q      <= ra_q + CntW'(1);
            cmp_idx_q <= ra_q[IdxW-1:0];
            pend_q    <= 1'b1;
          end else begin
            pend_q <= 1'b0;
          end
          if (pend_q) begin
            if (op_q == OP_TOTAL) begin
              acc_q <= acc_q + AccW'(rd_wgt_q);
            end else if (rd_key_q == key_q) begin
              res_idx_q <= cmp_idx_q;
              if (op_q == OP_FIND) begin
                res_fw_q <= rd_wgt_q;
                state_q  <= S_RESP;
              end else begin
                state_q <= S_MOVE_RD;
              end
            end
          end else if (ra_q >= count_q) begin
            if (op_q != OP_TOTAL) begin
              res_st_q <= ST_MISSING;
            end
            state_q <= S_RESP;
          end
        end
        S_MOVE_RD: begin
          state_q <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          count_q <= last_c;
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q <= 1'b1;
            rsp_st_q    <= res_st_q;
            rsp_idx_q   <= SlotW'(res_idx_q);
            rsp_fw_q    <= res_fw_q;
            rsp_sum_q   <= sum_sat;
            rsp_fill_q  <= FillW'(count_q);
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_st_q;
  assign rsp_o.slot_index   = rsp_idx_q;
  assign rsp_o.found_weight = rsp_fw_q;
  assign rsp_o.weight_sum   = rsp_sum_q;
  assign rsp_o.fill_count   = rsp_fill_q;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the linear key table: directed, capacity and random traffic.
`timescale 1ns / 1ps

module tb_top;
  import lkt_pkg::*;

  localparam logic [OpW-1:0] OpSpareA = 3'd5;
  localparam logic [OpW-1:0] OpSpareB = 3'd6;
  localparam logic [OpW-1:0] OpSpareC = 3'd7;

  localparam longint SumMax = (longint'(1) <<< (SumW - 1)) - 1;
  localparam longint SumMin = -(longint'(1) <<< (SumW - 1));

  localparam int unsigned CycleLimit = 600000;
  localparam int SettleCycles = 80;

  typedef struct {
    status_e                  status;
    logic [SlotW-1:0]         slot;
    logic signed [WgtW-1:0]   found_weight;
    logic signed [SumW-1:0]   weight_sum;
    logic [FillW-1:0]         fill;
  } table_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   req_valid = 1'b0;
  logic [OpW-1:0]         req_op = '0;
  logic signed [KeyW-1:0] req_key = '0;
  logic signed [WgtW-1:0] req_weight = '0;
  logic                   rsp_ready = 1'b0;

  lkt_req_if req_bus ();
  lkt_rsp_if rsp_bus ();

  assign req_bus.valid  = req_valid;
  assign req_bus.op     = req_op;
  assign req_bus.key    = req_key;
  assign req_bus.weight = req_weight;
  assign rsp_bus.ready  = rsp_ready;

  linear_key_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  logic signed [KeyW-1:0] tbl_key [SLOTS];
  logic signed [WgtW-1:0] tbl_weight [SLOTS];
  int                     tbl_count = 0;
  logic signed [KeyW-1:0] key_pool [8];

  table_reply_t reply_q [$];

  int          req_idle_pct = 0;
  int          rsp_stall_pct = 0;
  int          err_count = 0;
  int          sent_count = 0;
  int          checked_count = 0;
  int          full_adds = 0;
  int          missed_lookups = 0;
  int          totals_seen = 0;
  int unsigned cycle_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, reply_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  function automatic table_reply_t predict_reply(input logic [OpW-1:0] op,
                                                 input logic signed [KeyW-1:0] key,
                                                 input logic signed [WgtW-1:0] weight);
    table_reply_t r;
    int hit;
    longint acc;
    r.status = ST_OK;
    r.slot = '0;
    r.found_weight = '0;
    r.weight_sum = '0;
    hit = -1;
    acc = 0;
    if (op == OP_FIND || op == OP_REMOVE) begin
      for (int i = 0; i < tbl_count; i++) begin
        if (hit < 0 && tbl_key[i] == key) hit = i;
      end
      if (hit < 0) begin
        r.status = ST_MISSING;
        missed_lookups++;
      end else begin
        r.slot = SlotW'(hit);
      end
    end
    case (op)
      OP_ADD: begin
        if (tbl_count >= SLOTS) begin
          r.status = ST_FULL;
          full_adds++;
        end else begin
          tbl_key[tbl_count] = key;
          tbl_weight[tbl_count] = weight;
          r.slot = SlotW'(tbl_count);
          tbl_count++;
        end
      end
      OP_FIND: begin
        if (hit >= 0) r.found_weight = tbl_weight[hit];
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          tbl_key[hit] = tbl_key[tbl_count-1];
          tbl_weight[hit] = tbl_weight[tbl_count-1];
          tbl_count--;
        end
      end
      OP_TOTAL: begin
        for (int i = 0; i < tbl_count; i++) acc += longint'(tbl_weight[i]);
        if (acc > SumMax) acc = SumMax;
        if (acc < SumMin) acc = SumMin;
        r.weight_sum = acc[SumW-1:0];
        totals_seen++;
      end
      OP_CLEAR: tbl_count = 0;
      default: ;
    endcase
    r.fill = FillW'(tbl_count);
    return r;
  endfunction

  task automatic check_field(input string field, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_reply
    table_reply_t want;
    if (rst_ni && rsp_bus.valid && rsp_ready) begin
      if (reply_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected beat, expected none, got status %0d fill %0d",
                 $time, rsp_bus.status, rsp_bus.fill_count);
      end else begin
        want = reply_q.pop_front();
        check_field("status", want.status, rsp_bus.status);
        check_field("slot_index", want.slot, rsp_bus.slot_index);
        check_field("found_weight", want.found_weight, rsp_bus.found_weight);
        check_field("weight_sum", want.weight_sum, rsp_bus.weight_sum);
        check_field("fill_count", want.fill, rsp_bus.fill_count);
        checked_count++;
      end
    end
  end

  task automatic send_request(input logic [OpW-1:0] op, input logic signed [KeyW-1:0] key,
                              input logic signed [WgtW-1:0] weight);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < req_idle_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid  <= 1'b1;
    req_op     <= op;
    req_key    <= key;
    req_weight <= weight;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    reply_q.push_back(predict_reply(op, key, weight));
    sent_count++;
  endtask

  task automatic wait_for_replies();
    req_valid <= 1'b0;
    do @(posedge clk_i); while (reply_q.size() != 0);
  endtask

  function automatic logic signed [KeyW-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (tbl_count > 0 && r < 60) return tbl_key[$urandom_range(tbl_count - 1)];
    if (r < 85) return key_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  task automatic test_directed();
    send_request(OP_FIND, 32'sd0, 32'sd0);
    send_request(OP_REMOVE, 32'sd5, 32'sd0);
    send_request(OP_TOTAL, 32'sd0, 32'sd0);
    send_request(OP_ADD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_request(OP_ADD, 32'sh8000_0000, 32'sh8000_0000);
    send_request(OP_ADD, 32'sd0, 32'sd0);
    send_request(OP_ADD, -32'sd1, -32'sd1);
    send_request(OP_ADD, 32'sh7FFF_FFFF, 32'sd5);
    send_request(OP_FIND, 32'sh7FFF_FFFF, $urandom);
    send_request(OP_FIND, 32'sh8000_0000, 32'sd0);
    send_request(OP_FIND, 32'sd12345, 32'sd0);
    send_request(OP_TOTAL, $urandom, $urandom);
    send_request(OP_REMOVE, 32'sh7FFF_FFFF, 32'sd0);
    send_request(OP_FIND, 32'sh7FFF_FFFF, 32'sd0);
    send_request(OP_REMOVE, -32'sd1, 32'sd0);
    send_request(OP_REMOVE, 32'sh8000_0000, 32'sd0);
    send_request(OpSpareA, $urandom, $urandom);
    send_request(OpSpareB, $urandom, $urandom);
    send_request(OpSpareC, $urandom, $urandom);
    send_request(OP_TOTAL, 32'sd0, 32'sd0);
    send_request(OP_CLEAR, $urandom, $urandom);
    send_request(OP_FIND, 32'sd0, 32'sd0);
    send_request(OP_TOTAL, 32'sd0, 32'sd0);
    send_request(OP_ADD, 32'sd77, -32'sd77);
  endtask

  task automatic test_capacity();
    send_request(OP_CLEAR, 32'sd0, 32'sd0);
    for (int i = 0; i < SLOTS; i++) send_request(OP_ADD, $urandom, 32'sh7FFF_FFFF);
    send_request(OP_ADD, $urandom, $urandom);
    send_request(OP_TOTAL, 32'sd0, 32'sd0);
    send_request(OP_FIND, tbl_key[SLOTS-1], 32'sd0);
    send_request(OP_REMOVE, tbl_key[0], 32'sd0);
    send_request(OP_ADD, $urandom, $urandom);
    send_request(OP_ADD, $urandom, $urandom);
    send_request(OP_CLEAR, 32'sd0, 32'sd0);
    for (int i = 0; i < SLOTS; i++) send_request(OP_ADD, $urandom, 32'sh8000_0000);
    send_request(OP_TOTAL, 32'sd0, 32'sd0);
    send_request(OP_REMOVE, tbl_key[SLOTS-1], 32'sd0);
    send_request(OP_CLEAR, 32'sd0, 32'sd0);
  endtask

  task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct);
    int r;
    req_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        send_request(OP_ADD, ($urandom_range(1) != 0) ? key_pool[$urandom_range(7)] : $urandom,
                     $urandom);
      end else if (r < 63) begin
        send_request(OP_FIND, pick_key(), $urandom);
      end else if (r < 80) begin
        send_request(OP_REMOVE, pick_key(), $urandom);
      end else if (r < 90) begin
        send_request(OP_TOTAL, $urandom, $urandom);
      end else if (r < 92) begin
        send_request(OP_CLEAR, $urandom, $urandom);
      end else if (r < 96) begin
        send_request(OpW'($urandom_range(OpSpareA, OpSpareC)), $urandom, $urandom);
      end else begin
        send_request(OpW'($urandom_range(OpSpareC)), $urandom, $urandom);
      end
      if ($urandom_range(49) == 0) wait_for_replies();
    end
  endtask

  initial begin
    key_pool[0] = 32'sh7FFF_FFFF;
    key_pool[1] = 32'sh8000_0000;
    key_pool[2] = 32'sd0;
    key_pool[3] = -32'sd1;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    wait_for_replies();
    test_capacity();
    test_random_traffic(170, 0, 0);
    test_random_traffic(170, 60, 0);
    test_random_traffic(170, 0, 60);
    test_random_traffic(170, 13, 13);
    wait_for_replies();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d requests and checked %0d beats: %0d full-table adds, %0d missed lookups,",
             sent_count, checked_count, full_adds, missed_lookups);
    $display("%0d totals, under free flow, an idle sender, a stalling receiver and both at once.",
             totals_seen);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
